### sv/bndil_pkg.sv
package bndil_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int PIX_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 11;
    // result queue depth, a power of two so the pointers wrap on their own
    localparam int FIFO_DEPTH    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_WHITE_MODE   = 2'd2,
        REG_THRESHOLD    = 2'd3
    } cfg_reg_t;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_DATA_W-1:0] RST_WIDTH     = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT    = 11'd1024;
    localparam logic                  RST_WHITE     = 1'b1;
    localparam logic [PIX_W-1:0]      RST_THRESHOLD = 8'd127;

    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

    // one column of marks around a centre row
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } col_t;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pix;
    } result_t;

endpackage

### sv/bndil_ram.sv
module bndil_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word when the same entry is written at that edge
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/binary_neighbor_dilate_3x3.sv
// Channel   Direction  Beat contents
// s_        in         tdata = pixel_in, tuser = opcode (pixel or drain)
// m_        out        tdata = pixel_out (0 or 255), tlast = frame_end
// cfg_      in         cfg_index selects register, cfg_data = value (low bits)
//
// One item per clock while s_tready is high; a result passes the stage-1
// register and then the result queue before it reaches m_tvalid.
// Per-column line marks sit in one single-port-read memory, read at accept and
// written back the next cycle; a bypass covers back-to-back use of one column.
// aresetn (synchronous) restores the register defaults and restarts the frame.
// A four-entry result queue takes m_tready stalls; s_tready drops only when
// the queue and the result in flight would fill it.
module binary_neighbor_dilate_3x3 import bndil_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
    input  logic                  s_tuser,   // [0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // [7:0] pixel_out
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int KRW = $clog2(MAX_HEIGHT);
    localparam int FPW = $clog2(FIFO_DEPTH);
    localparam int FCW = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic          valid;
        logic          wr;
        logic          emit;
        logic          mark;
        logic [CW-1:0] addr;
        logic          top_clamp;
        logic          drain;
        logic          flat;
        logic          k_first;
        logic          k_last;
        logic          frame_end;
    } stage_t;

    // configuration
    logic [CFG_DATA_W-1:0] width_cfg_reg, width_cfg_next;
    logic [CFG_DATA_W-1:0] height_cfg_reg, height_cfg_next;
    logic                  white_reg, white_next;
    logic [PIX_W-1:0]      thr_reg, thr_next;
    logic                  cfg_we;
    logic                  restart;

    logic [WW-1:0]  w_eff;
    logic [RW-1:0]  h_eff;
    logic [CW-1:0]  wm1;
    logic [KRW-1:0] hm1;
    logic           h_one;

    // position counters
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  kc_reg, kc_next;
    logic [KRW-1:0] kr_reg, kr_next;
    logic           first_mark_reg, first_mark_next;

    logic          accept;
    logic          is_pix;
    logic          frame_in;
    logic          pix_take;
    logic          drain_take;
    logic          mark;
    logic          pix_emit;
    logic          emit0;
    logic          k_done;
    logic          col_last;
    logic [CW-1:0] col_inc;
    logic [CW-1:0] rd_addr;

    stage_t s1_reg, s1_next;

    // memory and bypass
    logic [1:0]    ram_q;
    logic [1:0]    line;
    logic          ram_we;
    logic [1:0]    ram_wd;
    logic          lw_valid_reg;
    logic [CW-1:0] lw_addr_reg;
    logic [1:0]    lw_data_reg;
    logic          upper;
    logic          middle;
    logic          fm;

    col_t arr;
    col_t a1_reg, a1_next;
    col_t a2_reg, a2_next;
    col_t lc, cc, rc;
    logic any_mark;

    // result queue
    result_t          fifo_mem_reg [FIFO_DEPTH];
    result_t          res;
    logic [FPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FCW-1:0]   fifo_cnt_reg, fifo_cnt_next;
    logic             push;
    logic             pop;
    logic [FCW:0]     credit;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    always_comb begin
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        white_next      = white_reg;
        thr_next        = thr_reg;
        restart         = 1'b0;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH: begin
                    width_cfg_next = cfg_data;
                    restart        = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    height_cfg_next = cfg_data;
                    restart         = 1'b1;
                end
                REG_WHITE_MODE: begin
                    white_next = cfg_data[0];
                    restart    = 1'b1;
                end
                REG_THRESHOLD: begin
                    thr_next = cfg_data[PIX_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_cfg_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = RW'(1);
        end else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(height_cfg_reg);
        end
    end

    assign wm1   = CW'(w_eff - WW'(1));
    assign hm1   = KRW'(h_eff - RW'(1));
    assign h_one = (h_eff == RW'(1));

    // ---------------------------------------------------------------- stage 0
    assign accept     = s_tvalid & s_tready;
    assign is_pix     = (s_tuser == OP_PIXEL);
    assign frame_in   = (row_reg < h_eff);
    assign pix_take   = accept & is_pix & frame_in;
    assign drain_take = accept & ~is_pix & ~frame_in;
    assign mark       = white_reg ? (s_tdata > thr_reg) : (s_tdata < thr_reg);
    // a pixel gives a result once a row and one pixel have gone by
    assign pix_emit   = (row_reg >= RW'(2)) || ((row_reg == RW'(1)) && (col_reg != '0));
    assign emit0      = (pix_take & pix_emit) | drain_take;
    assign k_done     = (kc_reg == wm1) && (kr_reg == hm1);
    assign col_last   = (col_reg == wm1);
    assign col_inc    = col_last ? '0 : col_reg + CW'(1);

    // a single-row frame drains one column ahead, clamped at the right edge
    assign rd_addr = (~is_pix & h_one & ~col_last) ? col_reg + CW'(1) : col_reg;

    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        kc_next         = kc_reg;
        kr_next         = kr_reg;
        first_mark_next = first_mark_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
            kc_next  = '0;
            kr_next  = '0;
        end else begin
            if (pix_take) begin
                col_next = col_inc;
                if (col_last) begin
                    row_next = row_reg + RW'(1);
                end
                if (row_reg == '0 && col_reg == '0) begin
                    first_mark_next = mark;
                end
            end
            if (drain_take) begin
                col_next = col_inc;
            end
            if (emit0) begin
                if (k_done) begin
                    col_next = '0;
                    row_next = '0;
                    kc_next  = '0;
                    kr_next  = '0;
                end else if (kc_reg == wm1) begin
                    kc_next = '0;
                    kr_next = kr_reg + KRW'(1);
                end else begin
                    kc_next = kc_reg + CW'(1);
                end
            end
        end
    end

    always_comb begin
        s1_next.valid     = pix_take | drain_take;
        s1_next.wr        = pix_take;
        s1_next.emit      = emit0;
        s1_next.mark      = mark;
        s1_next.addr      = rd_addr;
        s1_next.top_clamp = is_pix ? (row_reg == RW'(1)) : h_one;
        s1_next.drain     = ~is_pix;
        s1_next.flat      = is_pix & h_one;
        s1_next.k_first   = (kc_reg == '0);
        s1_next.k_last    = (kc_reg == wm1);
        s1_next.frame_end = k_done;
    end

    // ---------------------------------------------------------------- line marks
    // entry per column: bit 1 = row above, bit 0 = latest row
    bndil_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_reg.addr),
        .wr_data (ram_wd),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // take the word written at the edge of this read
    assign line   = (lw_valid_reg && lw_addr_reg == s1_reg.addr) ? lw_data_reg : ram_q;
    assign upper  = line[1];
    assign middle = line[0];
    assign ram_we = s1_reg.valid & s1_reg.wr;
    assign ram_wd = {middle, s1_reg.mark};
    assign fm     = first_mark_reg;

    // ---------------------------------------------------------------- stage 1
    always_comb begin
        if (s1_reg.flat) begin
            arr = '{top: fm, mid: fm, bot: fm};
        end else begin
            arr.top = s1_reg.top_clamp ? middle : upper;
            arr.mid = middle;
            arr.bot = s1_reg.drain ? middle : s1_reg.mark;
        end
    end

    always_comb begin
        a1_next = a1_reg;
        a2_next = a2_reg;
        if (s1_reg.valid) begin
            a1_next = arr;
            a2_next = a1_reg;
        end
    end

    // centre column is the previous arrival; clamp left and right at the edges
    assign cc = a1_reg;
    assign lc = s1_reg.k_first ? a1_reg : a2_reg;
    assign rc = s1_reg.k_last ? a1_reg : arr;

    assign any_mark = (|lc) | (|rc) | cc.top | cc.bot;

    assign res.pix  = (any_mark == white_reg) ? PIX_WHITE : PIX_BLACK;
    assign res.last = s1_reg.frame_end;
    assign push     = s1_reg.valid & s1_reg.emit;

    // ---------------------------------------------------------------- result queue
    assign pop      = m_tvalid & m_tready;
    assign credit   = (FCW + 1)'(fifo_cnt_reg) + (FCW + 1)'(push);
    assign s_tready = (credit < (FCW + 1)'(FIFO_DEPTH));

    always_comb begin
        wr_ptr_next   = push ? wr_ptr_reg + FPW'(1) : wr_ptr_reg;
        rd_ptr_next   = pop ? rd_ptr_reg + FPW'(1) : rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg;
        if (push && !pop) begin
            fifo_cnt_next = fifo_cnt_reg + FCW'(1);
        end else if (pop && !push) begin
            fifo_cnt_next = fifo_cnt_reg - FCW'(1);
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = fifo_mem_reg[rd_ptr_reg].pix;
    assign m_tlast  = fifo_mem_reg[rd_ptr_reg].last;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= RST_WIDTH;
            height_cfg_reg <= RST_HEIGHT;
            white_reg      <= RST_WHITE;
            thr_reg        <= RST_THRESHOLD;
            col_reg        <= '0;
            row_reg        <= '0;
            kc_reg         <= '0;
            kr_reg         <= '0;
            first_mark_reg <= 1'b0;
            s1_reg         <= '0;
            lw_valid_reg   <= 1'b0;
            a1_reg         <= '0;
            a2_reg         <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_cnt_reg   <= '0;
        end else begin
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            white_reg      <= white_next;
            thr_reg        <= thr_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            kc_reg         <= kc_next;
            kr_reg         <= kr_next;
            first_mark_reg <= first_mark_next;
            s1_reg         <= s1_next;
            lw_valid_reg   <= ram_we;
            a1_reg         <= a1_next;
            a2_reg         <= a2_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_cnt_reg   <= fifo_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        lw_addr_reg <= s1_reg.addr;
        lw_data_reg <= ram_wd;
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= res;
        end
    end

    // ---------------------------------------------------------------- checks
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        credit <= (FCW + 1)'(FIFO_DEPTH))
        else $error("result queue over-committed");

    a_binary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == PIX_WHITE || m_tdata == PIX_BLACK))
        else $error("result pixel not binary");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= wm1) && (kc_reg <= wm1) && (kr_reg <= hm1))
        else $error("position counter beyond frame");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit0 && k_done) |=> (row_reg == '0 && col_reg == '0 && kc_reg == '0 &&
                               kr_reg == '0))
        else $error("frame did not restart after its last result");

    a_end_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s1_reg.frame_end) |-> s1_reg.drain)
        else $error("frame end raised by a pixel beat");

endmodule
